/* src/ucdc_pkg.sv */
// ----------------------------------------------------------------------------
// ucdc_pkg
// Shared types, codes and descriptor tables for the endpoint-zero handler.
// ----------------------------------------------------------------------------
package ucdc_pkg;

  localparam int unsigned EP0_PACKET_BYTES_DEF   = 64;
  localparam int unsigned REPLY_BUFFER_BYTES_DEF = 128;

  // Event codes
  localparam logic [2:0] EV_SETUP   = 3'd0;
  localparam logic [2:0] EV_IN_DONE = 3'd1;
  localparam logic [2:0] EV_OUT_DONE = 3'd2;
  localparam logic [2:0] EV_BUS_RST = 3'd3;
  localparam logic [2:0] EV_DISCON  = 3'd4;

  // Action codes
  localparam logic [3:0] ACT_DATA       = 4'd0;
  localparam logic [3:0] ACT_ZLP        = 4'd1;
  localparam logic [3:0] ACT_OUT_STATUS = 4'd2;
  localparam logic [3:0] ACT_OUT7       = 4'd3;
  localparam logic [3:0] ACT_STALL      = 4'd4;
  localparam logic [3:0] ACT_ADDR       = 4'd5;
  localparam logic [3:0] ACT_OPEN       = 4'd6;
  localparam logic [3:0] ACT_CLOSE      = 4'd7;
  localparam logic [3:0] ACT_NONE       = 4'd8;

  // Request codes
  localparam logic [7:0] RQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] RQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] RQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] RQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] RQ_GET_DESC    = 8'h06;
  localparam logic [7:0] RQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] RQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] RQ_GET_IFACE   = 8'h0A;
  localparam logic [7:0] RQ_SET_IFACE   = 8'h0B;
  localparam logic [7:0] RQ_SET_LINE    = 8'h20;
  localparam logic [7:0] RQ_GET_LINE    = 8'h21;
  localparam logic [7:0] RQ_SET_CTRL    = 8'h22;

  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;

  localparam logic [55:0] LINE_CFG_RESET = 56'h0800000001C200;

  // Reply sources
  typedef enum logic [3:0] {
    SRC_DEVICE, SRC_CONFIG, SRC_LANG, SRC_STR1, SRC_STR2, SRC_STR3,
    SRC_CFGVAL, SRC_ZERO, SRC_LINE
  } src_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_LOAD, ST_PRE, ST_EMIT, ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_start;   // start buffer fill from the decoded source
    logic       load_step;    // write one byte
    logic       chunk_start;  // latch chunk size
    logic       emit_step;    // advance read pointer
    logic       commit;       // apply event state updates
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       load_done;
    logic       chunk_zero;   // nothing left to send
    logic       chunk_last;   // current byte closes the chunk
  } dp_sts_t;

  function automatic logic [7:0] rom_byte(input src_t s, input logic [6:0] i,
                                          input logic [7:0] ep0_size);
    logic [7:0] b;
    b = 8'h00;
    case (s)
      SRC_DEVICE: begin
        case (i)
          7'd0: b = 8'd18; 7'd1: b = 8'd1; 7'd3: b = 8'h02; 7'd4: b = 8'h02;
          7'd7: b = ep0_size; 7'd8: b = 8'h83; 7'd9: b = 8'h04; 7'd10: b = 8'h40;
          7'd11: b = 8'h57; 7'd13: b = 8'h01; 7'd14: b = 8'd1; 7'd15: b = 8'd2;
          7'd16: b = 8'd3; 7'd17: b = 8'd1;
          default: b = 8'h00;
        endcase
      end
      SRC_CONFIG: begin
        case (i)
          7'd0: b = 8'd9; 7'd1: b = 8'd2; 7'd2: b = 8'd67; 7'd4: b = 8'd2;
          7'd5: b = 8'd1; 7'd7: b = 8'h80; 7'd8: b = 8'd50;
          7'd9: b = 8'd9; 7'd10: b = 8'd4; 7'd13: b = 8'd1; 7'd14: b = 8'h02;
          7'd15: b = 8'h02; 7'd16: b = 8'h01;
          7'd18: b = 8'd5; 7'd19: b = 8'h24; 7'd21: b = 8'h10; 7'd22: b = 8'h01;
          7'd23: b = 8'd5; 7'd24: b = 8'h24; 7'd25: b = 8'h01; 7'd27: b = 8'd1;
          7'd28: b = 8'd4; 7'd29: b = 8'h24; 7'd30: b = 8'h02; 7'd31: b = 8'h02;
          7'd32: b = 8'd5; 7'd33: b = 8'h24; 7'd34: b = 8'h06; 7'd36: b = 8'd1;
          7'd37: b = 8'd7; 7'd38: b = 8'd5; 7'd39: b = 8'h81; 7'd40: b = 8'h03;
          7'd41: b = 8'd8; 7'd43: b = 8'd16;
          7'd44: b = 8'd9; 7'd45: b = 8'd4; 7'd46: b = 8'd1; 7'd48: b = 8'd2;
          7'd49: b = 8'h0A;
          7'd53: b = 8'd7; 7'd54: b = 8'd5; 7'd55: b = 8'h02; 7'd56: b = 8'h02;
          7'd57: b = 8'd64;
          7'd60: b = 8'd7; 7'd61: b = 8'd5; 7'd62: b = 8'h83; 7'd63: b = 8'h02;
          7'd64: b = 8'd64;
          default: b = 8'h00;
        endcase
      end
      SRC_LANG: begin
        case (i)
          7'd0: b = 8'd4; 7'd1: b = 8'd3; 7'd2: b = 8'h09; 7'd3: b = 8'h04;
          default: b = 8'h00;
        endcase
      end
      SRC_STR1: begin
        case (i)
          7'd0: b = 8'd20; 7'd1: b = 8'd3; 7'd2: b = 8'h45; 7'd4: b = 8'h6D;
          7'd6: b = 8'h62; 7'd8: b = 8'h65; 7'd10: b = 8'h64; 7'd12: b = 8'h46;
          7'd14: b = 8'h69; 7'd16: b = 8'h72; 7'd18: b = 8'h65;
          default: b = 8'h00;
        endcase
      end
      SRC_STR2: begin
        case (i)
          7'd0: b = 8'd46; 7'd1: b = 8'd3; 7'd2: b = 8'h53; 7'd4: b = 8'h54;
          7'd6: b = 8'h4D; 7'd8: b = 8'h33; 7'd10: b = 8'h32; 7'd12: b = 8'h20;
          7'd14: b = 8'h54; 7'd16: b = 8'h65; 7'd18: b = 8'h6D; 7'd20: b = 8'h70;
          7'd22: b = 8'h20; 7'd24: b = 8'h4D; 7'd26: b = 8'h6F; 7'd28: b = 8'h6E;
          7'd30: b = 8'h69; 7'd32: b = 8'h74; 7'd34: b = 8'h6F; 7'd36: b = 8'h72;
          7'd38: b = 8'h20; 7'd40: b = 8'h43; 7'd42: b = 8'h44; 7'd44: b = 8'h43;
          default: b = 8'h00;
        endcase
      end
      SRC_STR3: begin
        case (i)
          7'd0: b = 8'd18; 7'd1: b = 8'd3; 7'd2: b = 8'h30; 7'd4: b = 8'h30;
          7'd6: b = 8'h30; 7'd8: b = 8'h31; 7'd10: b = 8'h46; 7'd12: b = 8'h31;
          7'd14: b = 8'h30; 7'd16: b = 8'h33;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* src/ucdc_if.sv */
// ----------------------------------------------------------------------------
// ucdc_in_if / ucdc_out_if
// Valid/ready channels carrying endpoint-zero events and actions.
// ----------------------------------------------------------------------------
interface ucdc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  request_type_bits;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_length;
  logic [6:0]  out_count;
  logic [55:0] out_payload;
  modport source (output valid, req_type, request_type_bits, request_code,
                  request_value, request_length, out_count, out_payload,
                  input ready);
  modport sink (input valid, req_type, request_type_bits, request_code,
                request_value, request_length, out_count, out_payload,
                output ready);
endinterface

interface ucdc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] data_byte;
  logic [6:0] device_address;
  logic [7:0] configured_value;
  logic       last;
  modport source (output valid, action, data_byte, device_address,
                  configured_value, last, input ready);
  modport sink (input valid, action, data_byte, device_address,
                configured_value, last, output ready);
endinterface

/* src/ucdc_datapath.sv */
// ----------------------------------------------------------------------------
// ucdc_datapath
// Reply buffer, reply pointers, configuration and line coding storage.
// ----------------------------------------------------------------------------
module ucdc_datapath #(
  parameter int unsigned EP0_PACKET_BYTES   = ucdc_pkg::EP0_PACKET_BYTES_DEF,
  parameter int unsigned REPLY_BUFFER_BYTES = ucdc_pkg::REPLY_BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ucdc_pkg::dp_cmd_t  cmd,
  output ucdc_pkg::dp_sts_t  sts,
  // decoded event
  input  ucdc_pkg::src_t     src,
  input  logic [7:0]         src_len,
  input  logic [15:0]        req_len,
  input  logic               do_reply,      // decode starts a reply
  input  logic               do_status,     // commit clears the reply
  input  logic               do_busreset,
  input  logic               do_setcfg,
  input  logic               do_clrcfg,
  input  logic               do_line,
  input  logic               set_await,
  input  logic               clr_await,
  input  logic               in_done_zlp,   // IN done takes the trailing packet
  input  logic [7:0]         cfg_wr,
  input  logic [55:0]        payload,
  output logic               await_line,
  output logic               has_data,
  output logic               trail_pend,
  output logic [7:0]         cfg_value,
  output logic [7:0]         rd_byte
);

  localparam int unsigned AW = $clog2(REPLY_BUFFER_BYTES);
  localparam int unsigned LW = $clog2(REPLY_BUFFER_BYTES + 1);
  localparam int unsigned CW = $clog2(EP0_PACKET_BYTES + 1);

  logic [7:0]  mem [REPLY_BUFFER_BYTES];
  logic [LW-1:0] rlen, rpos, wcnt, wlen;
  logic [CW-1:0] ccnt;
  logic [55:0] line;
  logic [7:0]  wbyte;
  logic [16:0] clip;
  logic [LW-1:0] clip_len, remain;
  logic          trail_next;

  // Clip reply length to the host request and the buffer size
  always_comb begin
    clip = {9'd0, src_len};
    if ({1'b0, req_len} < clip) clip = {1'b0, req_len};
    if (clip > 17'(REPLY_BUFFER_BYTES)) clip = 17'(REPLY_BUFFER_BYTES);
    clip_len = LW'(clip);
    trail_next = (clip < {1'b0, req_len}) && (clip % 17'(EP0_PACKET_BYTES) == 17'd0);
  end

  // Select the byte to store
  always_comb begin
    case (src)
      ucdc_pkg::SRC_CFGVAL: wbyte = (wcnt == '0) ? cfg_value : 8'h00;
      ucdc_pkg::SRC_ZERO:   wbyte = 8'h00;
      ucdc_pkg::SRC_LINE:   wbyte = line[{wcnt[2:0], 3'b000} +: 8];
      default: wbyte = ucdc_pkg::rom_byte(src, 7'(wcnt), 8'(EP0_PACKET_BYTES));
    endcase
  end

  // Fill and read the reply buffer
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin end
    if (cmd.load_step) mem[AW'(wcnt)] <= wbyte;
    rd_byte <= mem[AW'(cmd.emit_step ? rpos + LW'(1) : rpos)];
  end

  assign remain = rlen - rpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      rlen <= '0; rpos <= '0; trail_pend <= 1'b0; cfg_value <= 8'h00;
      await_line <= 1'b0; line <= ucdc_pkg::LINE_CFG_RESET;
      wcnt <= '0; wlen <= '0; ccnt <= '0;
    end else begin
      // load counter
      if (cmd.load_start) begin
        wcnt <= '0;
        wlen <= clip_len;
      end else if (cmd.load_step) begin
        wcnt <= wcnt + LW'(1);
      end
      // chunk counter
      if (cmd.chunk_start) begin
        ccnt <= (remain > LW'(EP0_PACKET_BYTES)) ? CW'(EP0_PACKET_BYTES) : CW'(remain);
      end else if (cmd.emit_step) begin
        ccnt <= ccnt - CW'(1);
        rpos <= rpos + LW'(1);
      end
      // set up the reply pointers at decode so the first chunk sees them
      if (cmd.load_start && do_reply) begin
        rlen <= clip_len; rpos <= '0; trail_pend <= trail_next;
      end
      // event state
      if (cmd.commit) begin
        if (do_status || do_busreset) begin
          rlen <= '0; rpos <= '0; trail_pend <= 1'b0;
        end
        if (in_done_zlp) trail_pend <= 1'b0;
        if (do_setcfg) cfg_value <= cfg_wr;
        if (do_clrcfg) cfg_value <= 8'h00;
        if (do_line) line <= payload;
        if (set_await) await_line <= 1'b1;
        if (clr_await) await_line <= 1'b0;
      end
    end
  end

  assign has_data = rpos < rlen;
  assign sts.load_done  = (wcnt == wlen);
  assign sts.chunk_zero = (remain == '0);
  assign sts.chunk_last = (ccnt == CW'(1));

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (rst) rpos <= rlen)
    else $error("reply position past reply length");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rlen <= LW'(REPLY_BUFFER_BYTES)) else $error("reply length past buffer");
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> ccnt != '0) else $error("emit past chunk end");
`endif

endmodule

/* src/ucdc_ctrl.sv */
// ----------------------------------------------------------------------------
// ucdc_ctrl
// Event decode and sequencing of buffer fill and result emission.
// ----------------------------------------------------------------------------
module ucdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  ucdc_in_if.sink            in_ch,
  ucdc_out_if.source         out_ch,
  output ucdc_pkg::dp_cmd_t  cmd,
  input  ucdc_pkg::dp_sts_t  sts,
  output ucdc_pkg::src_t     src,
  output logic [7:0]         src_len,
  output logic [15:0]        req_len,
  output logic               do_reply,
  output logic               do_status,
  output logic               do_busreset,
  output logic               do_setcfg,
  output logic               do_clrcfg,
  output logic               do_line,
  output logic               set_await,
  output logic               clr_await,
  output logic               in_done_zlp,
  output logic [7:0]         cfg_wr,
  output logic [55:0]        payload,
  input  logic               await_line,
  input  logic               has_data,
  input  logic               trail_pend,
  input  logic [7:0]         cfg_value,
  input  logic [7:0]         rd_byte
);

  ucdc_pkg::state_t state, state_next;

  // latched event
  logic [2:0]  ev;
  logic [1:0]  rtype;
  logic [7:0]  code;
  logic [15:0] value;
  logic [6:0]  cnt;

  // decoded single action (before optional status/data)
  logic [3:0]  pre_act;     // first action
  logic        has_pre;     // a first result precedes the main one
  logic [3:0]  main_act;    // main single result when not sending data
  logic        send_data;   // main part is a chunk of the buffer
  logic        is_stall;

  // output register
  logic        ovalid;
  logic [3:0]  oact;
  logic [7:0]  obyte;
  logic [6:0]  oaddr;
  logic        olast;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ev <= in_ch.req_type;
      rtype <= in_ch.request_type_bits[6:5];
      code <= in_ch.request_code;
      value <= in_ch.request_value;
      req_len <= in_ch.request_length;
      cnt <= in_ch.out_count;
      payload <= in_ch.out_payload;
    end
  end

  // Decode the latched event
  always_comb begin
    src = ucdc_pkg::SRC_ZERO; src_len = 8'd0;
    do_reply = 1'b0; do_status = 1'b0; do_busreset = 1'b0; do_setcfg = 1'b0;
    do_clrcfg = 1'b0; do_line = 1'b0; set_await = 1'b0; clr_await = 1'b0;
    in_done_zlp = 1'b0; cfg_wr = value[7:0];
    pre_act = ucdc_pkg::ACT_NONE; has_pre = 1'b0; main_act = ucdc_pkg::ACT_NONE;
    send_data = 1'b0; is_stall = 1'b0;
    case (ev)
      ucdc_pkg::EV_SETUP: begin
        clr_await = 1'b1;
        if (rtype == ucdc_pkg::RT_STANDARD) begin
          case (code)
            ucdc_pkg::RQ_GET_DESC: begin
              do_reply = 1'b1;
              if (value[15:8] == 8'd1) begin
                src = ucdc_pkg::SRC_DEVICE; src_len = 8'd18;
              end else if (value[15:8] == 8'd2) begin
                src = ucdc_pkg::SRC_CONFIG; src_len = 8'd67;
              end else if (value[15:8] == 8'd3 && value[7:0] == 8'd0) begin
                src = ucdc_pkg::SRC_LANG; src_len = 8'd4;
              end else if (value[15:8] == 8'd3 && value[7:0] == 8'd1) begin
                src = ucdc_pkg::SRC_STR1; src_len = 8'd20;
              end else if (value[15:8] == 8'd3 && value[7:0] == 8'd2) begin
                src = ucdc_pkg::SRC_STR2; src_len = 8'd46;
              end else if (value[15:8] == 8'd3 && value[7:0] == 8'd3) begin
                src = ucdc_pkg::SRC_STR3; src_len = 8'd18;
              end else begin
                do_reply = 1'b0; is_stall = 1'b1;
              end
            end
            ucdc_pkg::RQ_SET_ADDRESS: begin
              has_pre = 1'b1; pre_act = ucdc_pkg::ACT_ADDR;
              do_status = 1'b1; main_act = ucdc_pkg::ACT_ZLP;
            end
            ucdc_pkg::RQ_SET_CONFIG: begin
              do_setcfg = 1'b1; has_pre = 1'b1;
              pre_act = (value[7:0] != 8'd0) ? ucdc_pkg::ACT_OPEN : ucdc_pkg::ACT_CLOSE;
              do_status = 1'b1; main_act = ucdc_pkg::ACT_ZLP;
            end
            ucdc_pkg::RQ_GET_CONFIG: begin
              do_reply = 1'b1; src = ucdc_pkg::SRC_CFGVAL; src_len = 8'd1;
            end
            ucdc_pkg::RQ_GET_STATUS: begin
              do_reply = 1'b1; src = ucdc_pkg::SRC_ZERO; src_len = 8'd2;
            end
            ucdc_pkg::RQ_GET_IFACE: begin
              do_reply = 1'b1; src = ucdc_pkg::SRC_ZERO; src_len = 8'd1;
            end
            ucdc_pkg::RQ_SET_IFACE, ucdc_pkg::RQ_CLR_FEATURE,
            ucdc_pkg::RQ_SET_FEATURE: begin
              do_status = 1'b1; main_act = ucdc_pkg::ACT_ZLP;
            end
            default: is_stall = 1'b1;
          endcase
        end else if (rtype == ucdc_pkg::RT_CLASS) begin
          case (code)
            ucdc_pkg::RQ_GET_LINE: begin
              do_reply = 1'b1; src = ucdc_pkg::SRC_LINE; src_len = 8'd7;
            end
            ucdc_pkg::RQ_SET_LINE: begin
              set_await = 1'b1; clr_await = 1'b0; main_act = ucdc_pkg::ACT_OUT7;
            end
            ucdc_pkg::RQ_SET_CTRL: begin
              do_status = 1'b1; main_act = ucdc_pkg::ACT_ZLP;
            end
            default: is_stall = 1'b1;
          endcase
        end else begin
          is_stall = 1'b1;
        end
        if (is_stall) main_act = ucdc_pkg::ACT_STALL;
        send_data = do_reply;
      end
      ucdc_pkg::EV_IN_DONE: begin
        if (has_data) begin
          send_data = 1'b1;
        end else if (trail_pend) begin
          in_done_zlp = 1'b1; main_act = ucdc_pkg::ACT_ZLP;
        end else begin
          main_act = ucdc_pkg::ACT_OUT_STATUS;
        end
      end
      ucdc_pkg::EV_OUT_DONE: begin
        do_line = await_line && (cnt == 7'd7);
        clr_await = 1'b1; do_status = 1'b1; main_act = ucdc_pkg::ACT_ZLP;
      end
      ucdc_pkg::EV_BUS_RST: begin
        do_busreset = 1'b1; do_clrcfg = 1'b1; clr_await = 1'b1;
      end
      ucdc_pkg::EV_DISCON: do_clrcfg = 1'b1;
      default: main_act = ucdc_pkg::ACT_NONE;
    endcase
  end

  wire obusy = ovalid && !out_ch.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ucdc_pkg::ST_IDLE:   if (in_ch.valid) state_next = ucdc_pkg::ST_DECODE;
      ucdc_pkg::ST_DECODE: state_next = (do_reply && ev == ucdc_pkg::EV_SETUP)
                                        ? ucdc_pkg::ST_LOAD : ucdc_pkg::ST_PRE;
      ucdc_pkg::ST_LOAD:   if (sts.load_done) state_next = ucdc_pkg::ST_PRE;
      ucdc_pkg::ST_PRE: begin
        if (!obusy) begin
          if (has_pre) state_next = ucdc_pkg::ST_DONE;
          else if (send_data && !sts.chunk_zero) state_next = ucdc_pkg::ST_EMIT;
          else state_next = ucdc_pkg::ST_IDLE;
        end
      end
      ucdc_pkg::ST_DONE:   if (!obusy) state_next = ucdc_pkg::ST_IDLE;
      ucdc_pkg::ST_EMIT:   if (!obusy && sts.chunk_last) state_next = ucdc_pkg::ST_IDLE;
      default: state_next = ucdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ucdc_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ch.ready = (state == ucdc_pkg::ST_IDLE);
    case (state)
      ucdc_pkg::ST_DECODE: cmd.load_start = 1'b1;
      ucdc_pkg::ST_LOAD:   cmd.load_step = !sts.load_done;
      ucdc_pkg::ST_PRE: begin
        cmd.commit = !obusy;
        cmd.chunk_start = !obusy;
      end
      ucdc_pkg::ST_EMIT:   cmd.emit_step = !obusy;
      default: cmd = '0;
    endcase
  end

  // Output register: hold while stalled, load one beat per step
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (!obusy) begin
      ovalid <= 1'b0;
      case (state)
        ucdc_pkg::ST_PRE: begin
          ovalid <= has_pre || !(send_data && !sts.chunk_zero);
          oact <= has_pre ? pre_act : (send_data ? ucdc_pkg::ACT_ZLP : main_act);
          oaddr <= (has_pre && pre_act == ucdc_pkg::ACT_ADDR) ? value[6:0] : 7'd0;
          obyte <= 8'd0;
          olast <= !has_pre;
        end
        ucdc_pkg::ST_DONE: begin
          ovalid <= 1'b1; oact <= main_act; oaddr <= 7'd0; obyte <= 8'd0;
          olast <= 1'b1;
        end
        ucdc_pkg::ST_EMIT: begin
          ovalid <= 1'b1; oact <= ucdc_pkg::ACT_DATA; oaddr <= 7'd0;
          obyte <= rd_byte; olast <= sts.chunk_last;
        end
        default: ovalid <= 1'b0;
      endcase
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.action = oact;
  assign out_ch.data_byte = obyte;
  assign out_ch.device_address = oaddr;
  assign out_ch.configured_value = cfg_value;
  assign out_ch.last = olast;

`ifndef NO_ASSERTIONS
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ucdc_pkg::ST_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(oact))
    else $error("beat dropped while stalled");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (state == ucdc_pkg::ST_LOAD && sts.load_done) |=> state == ucdc_pkg::ST_PRE)
    else $error("fill did not finish");
`endif

endmodule

/* src/usb_cdc_control_endpoint.sv */
// ----------------------------------------------------------------------------
// usb_cdc_control_endpoint
// Endpoint-zero request handler with descriptor ROMs and CDC line coding.
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  in_ch    | in  | one endpoint-zero event per beat
//  out_ch   | out | one action per beat, last marks the event's final beat
//
// An event is accepted in idle and decoded in the next cycle. A reply fills the
// reply buffer one byte a cycle, then, while the output is not stalled, streams
// one byte a cycle through the single buffer read port, up to EP0_PACKET_BYTES
// per event. Other events give one or two beats. A stalled output holds the
// current beat. Synchronous reset clears all but buffer, event and output data.
module usb_cdc_control_endpoint #(
  parameter int unsigned EP0_PACKET_BYTES   = ucdc_pkg::EP0_PACKET_BYTES_DEF,
  parameter int unsigned REPLY_BUFFER_BYTES = ucdc_pkg::REPLY_BUFFER_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  ucdc_in_if.sink    in_ch,
  ucdc_out_if.source out_ch
);

  ucdc_pkg::dp_cmd_t cmd;
  ucdc_pkg::dp_sts_t sts;
  ucdc_pkg::src_t    src;
  logic [7:0]  src_len, cfg_wr, cfg_value, rd_byte;
  logic [15:0] req_len;
  logic [55:0] payload;
  logic do_reply, do_status, do_busreset, do_setcfg, do_clrcfg, do_line;
  logic set_await, clr_await, in_done_zlp, await_line, has_data, trail_pend;

  ucdc_ctrl u_ctrl (
    .clk, .rst, .in_ch, .out_ch, .cmd, .sts, .src, .src_len, .req_len,
    .do_reply, .do_status, .do_busreset, .do_setcfg, .do_clrcfg, .do_line,
    .set_await, .clr_await, .in_done_zlp, .cfg_wr, .payload, .await_line,
    .has_data, .trail_pend, .cfg_value, .rd_byte
  );

  ucdc_datapath #(
    .EP0_PACKET_BYTES(EP0_PACKET_BYTES), .REPLY_BUFFER_BYTES(REPLY_BUFFER_BYTES)
  ) u_dp (
    .clk, .rst, .cmd, .sts, .src, .src_len, .req_len,
    .do_reply, .do_status, .do_busreset, .do_setcfg, .do_clrcfg, .do_line,
    .set_await, .clr_await, .in_done_zlp, .cfg_wr, .payload, .await_line,
    .has_data, .trail_pend, .cfg_value, .rd_byte
  );

endmodule
